[rtl/dkt_pkg.sv]
// Package with the shared types, widths and codes of the demux key table.
package dkt_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int KEY_BYTES = 7;

  localparam int KEY_W = 56;
  localparam int HAND_W = 4;
  localparam int FEED_W = 8;
  localparam int SEQ_W = 32;
  localparam int ENTRY_W = KEY_W + HAND_W + FEED_W + SEQ_W;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  localparam logic [KEY_W-1:0] KEY_MASK = KEY_W'((65'd1 << (8 * KEY_BYTES)) - 65'd1);

  localparam logic [1:0] ACT_ARM = 2'd0;
  localparam logic [1:0] ACT_REMOVE = 2'd1;
  localparam int ACT_LOOKUP_BIT = 1;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_ABSENT = 2'd2;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [HAND_W-1:0] handler;
    logic [FEED_W-1:0] feed;
    logic [SEQ_W-1:0]  seq;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_WRITE,
    S_SH_RD,
    S_SH_WR,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic       start;
    logic       scan_step;
    logic       scan_end;
    logic [1:0] code;
    logic       wr_arm;
    logic       sh_read;
    logic       sh_write;
    logic       cnt_dec;
    logic       load_result;
  } cmd_t;

  typedef struct packed {
    logic is_lookup;
    logic is_remove;
    logic hit;
    logic exhausted;
    logic full;
    logic sh_more;
    logic out_free;
  } stat_t;

endpackage

[rtl/dkt_ram.sv]
// Generic single write port, single read port RAM with registered read data.
module dkt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/dkt_ctrl.sv]
// Controller state machine that sequences the scan, update and shift of the key table.
module dkt_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  dkt_pkg::stat_t  stat,
  output dkt_pkg::cmd_t   cmd
);

  dkt_pkg::state_t state;
  dkt_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dkt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      dkt_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = dkt_pkg::S_SCAN;
        end
      end
      dkt_pkg::S_SCAN: begin
        if (stat.hit || stat.exhausted) begin
          if (stat.is_lookup) begin
            state_next = dkt_pkg::S_FINISH;
          end else if (stat.is_remove) begin
            state_next = stat.hit ? dkt_pkg::S_SH_RD : dkt_pkg::S_FINISH;
          end else begin
            state_next = (stat.hit || !stat.full) ? dkt_pkg::S_WRITE : dkt_pkg::S_FINISH;
          end
        end
      end
      dkt_pkg::S_WRITE: begin
        state_next = dkt_pkg::S_FINISH;
      end
      dkt_pkg::S_SH_RD: begin
        state_next = stat.sh_more ? dkt_pkg::S_SH_WR : dkt_pkg::S_FINISH;
      end
      dkt_pkg::S_SH_WR: begin
        state_next = dkt_pkg::S_SH_RD;
      end
      dkt_pkg::S_FINISH: begin
        if (stat.out_free) begin
          state_next = dkt_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = dkt_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    case (state)
      dkt_pkg::S_IDLE: begin
        in_stall = 1'b0;
        cmd.start = in_valid;
      end
      dkt_pkg::S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.hit || stat.exhausted) begin
          cmd.scan_end = 1'b1;
          if (stat.is_lookup || stat.is_remove) begin
            cmd.code = stat.hit ? dkt_pkg::ST_OK : dkt_pkg::ST_ABSENT;
          end else begin
            cmd.code = (stat.hit || !stat.full) ? dkt_pkg::ST_OK : dkt_pkg::ST_FULL;
          end
        end
      end
      dkt_pkg::S_WRITE: begin
        cmd.wr_arm = 1'b1;
      end
      dkt_pkg::S_SH_RD: begin
        cmd.sh_read = stat.sh_more;
        cmd.cnt_dec = !stat.sh_more;
      end
      dkt_pkg::S_SH_WR: begin
        cmd.sh_write = 1'b1;
      end
      dkt_pkg::S_FINISH: begin
        cmd.load_result = stat.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

[rtl/dkt_dpath.sv]
// Datapath with the entry memory, scan and shift pointers, count and result register.
module dkt_dpath (
  input  logic                        clk,
  input  logic                        rst,
  input  dkt_pkg::cmd_t               cmd,
  output dkt_pkg::stat_t              stat,
  input  logic [1:0]                  action,
  input  logic [dkt_pkg::KEY_W-1:0]   key,
  input  logic [dkt_pkg::HAND_W-1:0]  handler_id,
  input  logic [dkt_pkg::FEED_W-1:0]  feed_ref,
  input  logic [dkt_pkg::SEQ_W-1:0]   seq_in,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  status,
  output logic [dkt_pkg::HAND_W-1:0]  handler_out,
  output logic [dkt_pkg::FEED_W-1:0]  feed_out,
  output logic [dkt_pkg::SEQ_W-1:0]   seq_out
);

  logic [1:0]                  op_act;
  dkt_pkg::entry_t             op_entry;
  logic [dkt_pkg::CNT_W-1:0]   count;
  logic [dkt_pkg::CNT_W-1:0]   idx;
  logic                        rd_vld;
  logic [dkt_pkg::IDX_W-1:0]   cmp_idx;
  logic                        hit_flag;
  logic [dkt_pkg::IDX_W-1:0]   hit_slot;
  dkt_pkg::entry_t             hit_data;
  logic [dkt_pkg::IDX_W-1:0]   sh_ptr;
  logic [1:0]                  code;

  logic                        can_issue;
  logic                        scan_hit;
  logic [dkt_pkg::CNT_W-1:0]   sh_next;
  logic                        rd_en;
  logic [dkt_pkg::IDX_W-1:0]   rd_addr;
  logic [dkt_pkg::ENTRY_W-1:0] rd_data;
  dkt_pkg::entry_t             rd_entry;
  logic                        wr_en;
  logic [dkt_pkg::IDX_W-1:0]   wr_addr;
  logic [dkt_pkg::ENTRY_W-1:0] wr_data;
  logic                        out_free;

  assign rd_entry  = dkt_pkg::entry_t'(rd_data);
  assign can_issue = idx < count;
  assign scan_hit  = rd_vld && (rd_entry.key == op_entry.key);
  assign sh_next   = dkt_pkg::CNT_W'(sh_ptr) + dkt_pkg::CNT_W'(1);
  assign out_free  = !out_valid || !out_stall;

  assign rd_en   = (cmd.scan_step && can_issue && !scan_hit) || cmd.sh_read;
  assign rd_addr = cmd.sh_read ? sh_next[dkt_pkg::IDX_W-1:0] : idx[dkt_pkg::IDX_W-1:0];
  assign wr_en   = cmd.wr_arm || cmd.sh_write;
  assign wr_addr = cmd.sh_write ? sh_ptr :
                   (hit_flag ? hit_slot : count[dkt_pkg::IDX_W-1:0]);
  assign wr_data = cmd.sh_write ? rd_data : op_entry;

  assign stat.is_lookup = op_act[dkt_pkg::ACT_LOOKUP_BIT];
  assign stat.is_remove = (op_act == dkt_pkg::ACT_REMOVE);
  assign stat.hit       = scan_hit;
  assign stat.exhausted = !rd_vld && (idx == count);
  assign stat.full      = (count == dkt_pkg::CNT_W'(dkt_pkg::TABLE_DEPTH));
  assign stat.sh_more   = sh_next < count;
  assign stat.out_free  = out_free;

  dkt_ram #(
    .WIDTH (dkt_pkg::ENTRY_W),
    .DEPTH (dkt_pkg::TABLE_DEPTH)
  ) u_entries (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_act           <= action;
      op_entry.key     <= key & dkt_pkg::KEY_MASK;
      op_entry.handler <= handler_id;
      op_entry.feed    <= feed_ref;
      op_entry.seq     <= seq_in;
    end
    if (cmd.scan_step) begin
      cmp_idx <= idx[dkt_pkg::IDX_W-1:0];
      if (scan_hit) begin
        hit_slot <= cmp_idx;
        hit_data <= rd_entry;
        sh_ptr   <= cmp_idx;
      end
    end
    if (cmd.sh_write) begin
      sh_ptr <= sh_next[dkt_pkg::IDX_W-1:0];
    end
    if (cmd.scan_end) begin
      code <= cmd.code;
    end
    if (cmd.load_result) begin
      status <= code;
      if (stat.is_lookup && hit_flag) begin
        handler_out <= hit_data.handler;
        feed_out    <= hit_data.feed;
        seq_out     <= hit_data.seq;
      end else begin
        handler_out <= '0;
        feed_out    <= '0;
        seq_out     <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      idx       <= '0;
      rd_vld    <= 1'b0;
      hit_flag  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.start) begin
        idx      <= '0;
        rd_vld   <= 1'b0;
        hit_flag <= 1'b0;
      end else if (cmd.scan_step) begin
        rd_vld <= can_issue && !scan_hit;
        if (can_issue && !scan_hit) begin
          idx <= idx + dkt_pkg::CNT_W'(1);
        end
        if (scan_hit) begin
          hit_flag <= 1'b1;
        end
      end
      if (cmd.wr_arm && !hit_flag) begin
        count <= count + dkt_pkg::CNT_W'(1);
      end else if (cmd.cnt_dec) begin
        count <= count - dkt_pkg::CNT_W'(1);
      end
      if (cmd.load_result) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= dkt_pkg::CNT_W'(dkt_pkg::TABLE_DEPTH))
    else $error("Entry count exceeds the table depth.");

  a_scan_bound : assert property (@(posedge clk) disable iff (rst)
    cmd.scan_step |-> idx <= count)
    else $error("Scan pointer ran past the live entries.");

  a_append_room : assert property (@(posedge clk) disable iff (rst)
    (cmd.wr_arm && !hit_flag) |-> !stat.full)
    else $error("Append issued into a full table.");

  a_shift_live : assert property (@(posedge clk) disable iff (rst)
    cmd.sh_write |-> sh_next < count)
    else $error("Shift wrote beyond the live entries.");

  a_load_free : assert property (@(posedge clk) disable iff (rst)
    cmd.load_result |-> out_free)
    else $error("Result loaded over a word still waiting to be taken.");

endmodule

[rtl/demux_key_table.sv]
// Top level of the demux key table: exact-match key to handler lookup with arm and remove.
// One item at a time; the entries sit in a one-port-read RAM walked one slot per cycle.
// Lookup scans from slot 0 until a key hits or the live entries end, then loads the result
// word once the output is free. Arm adds a write step if it stores; remove moves each later
// entry down by a read and a write step. A new word is accepted the cycle after the result
// loads. Reset empties the table and clears control state; entry contents are not cleared.
module demux_key_table (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  action,
  input  logic [dkt_pkg::KEY_W-1:0]   key,
  input  logic [dkt_pkg::HAND_W-1:0]  handler_id,
  input  logic [dkt_pkg::FEED_W-1:0]  feed_ref,
  input  logic [dkt_pkg::SEQ_W-1:0]   seq_in,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  status,
  output logic [dkt_pkg::HAND_W-1:0]  handler_out,
  output logic [dkt_pkg::FEED_W-1:0]  feed_out,
  output logic [dkt_pkg::SEQ_W-1:0]   seq_out
);

  dkt_pkg::cmd_t  cmd;
  dkt_pkg::stat_t stat;

  dkt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  dkt_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .action      (action),
    .key         (key),
    .handler_id  (handler_id),
    .feed_ref    (feed_ref),
    .seq_in      (seq_in),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .handler_out (handler_out),
    .feed_out    (feed_out),
    .seq_out     (seq_out)
  );

endmodule

[dv/demux_key_table_test.sv]
// Self-checking testbench of the demux key table with a queue-fed driver and a checking monitor.
module demux_key_table_test;
  timeunit 1ns;
  timeprecision 1ps;

  import dkt_pkg::*;

  localparam logic [1:0] ACT_LOOKUP = 2'd2;
  localparam logic [1:0] ACT_SPARE = 2'd3;
  localparam int RANDOM_WORDS = 1050;
  localparam int POOL_SIZE = 24;
  localparam int PRESSURE_AT = 400;
  localparam int PRESSURE_CYCLES = 300;
  localparam int DRAIN_CYCLES = 80;

  typedef struct packed {
    logic [1:0]        action;
    logic [KEY_W-1:0]  key;
    logic [HAND_W-1:0] handler;
    logic [FEED_W-1:0] feed;
    logic [SEQ_W-1:0]  seq;
  } table_word_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [HAND_W-1:0] handler;
    logic [FEED_W-1:0] feed;
    logic [SEQ_W-1:0]  seq;
  } table_reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] action = '0;
  logic [KEY_W-1:0] key = '0;
  logic [HAND_W-1:0] handler_id = '0;
  logic [FEED_W-1:0] feed_ref = '0;
  logic [SEQ_W-1:0] seq_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] status;
  logic [HAND_W-1:0] handler_out;
  logic [FEED_W-1:0] feed_out;
  logic [SEQ_W-1:0] seq_out;

  table_word_t words_to_send[$];
  table_reply_t replies_due[$];
  table_word_t word_on_bus;

  logic [KEY_W-1:0] known_key[TABLE_DEPTH];
  logic [HAND_W-1:0] known_handler[TABLE_DEPTH];
  logic [FEED_W-1:0] known_feed[TABLE_DEPTH];
  logic [SEQ_W-1:0] known_seq[TABLE_DEPTH];
  int live_entries = 0;

  int words_sent = 0;
  int replies_seen = 0;
  int failures = 0;
  int send_gap = 0;
  int hold_left = 0;
  bit pressure_done = 1'b0;

  demux_key_table i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .action     (action),
    .key        (key),
    .handler_id (handler_id),
    .feed_ref   (feed_ref),
    .seq_in     (seq_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .handler_out(handler_out),
    .feed_out   (feed_out),
    .seq_out    (seq_out)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic table_reply_t table_apply(input table_word_t w);
    table_reply_t r;
    logic [KEY_W-1:0] k;
    int hit_at;
    r = '0;
    k = w.key & KEY_MASK;
    hit_at = -1;
    for (int i = 0; i < live_entries; i++) begin
      if (hit_at < 0 && known_key[i] == k) hit_at = i;
    end
    if (w.action[ACT_LOOKUP_BIT]) begin
      if (hit_at >= 0) begin
        r.handler = known_handler[hit_at];
        r.feed = known_feed[hit_at];
        r.seq = known_seq[hit_at];
      end else begin
        r.status = ST_ABSENT;
      end
    end else if (w.action == ACT_REMOVE) begin
      if (hit_at >= 0) begin
        for (int i = hit_at; i + 1 < live_entries; i++) begin
          known_key[i] = known_key[i + 1];
          known_handler[i] = known_handler[i + 1];
          known_feed[i] = known_feed[i + 1];
          known_seq[i] = known_seq[i + 1];
        end
        live_entries--;
      end else begin
        r.status = ST_ABSENT;
      end
    end else begin
      if (hit_at < 0) begin
        if (live_entries >= TABLE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          hit_at = live_entries;
          live_entries++;
        end
      end
      if (hit_at >= 0) begin
        known_key[hit_at] = k;
        known_handler[hit_at] = w.handler;
        known_feed[hit_at] = w.feed;
        known_seq[hit_at] = w.seq;
      end
    end
    return r;
  endfunction

  task automatic queue_word(input logic [1:0] act, input logic [KEY_W-1:0] k,
                            input logic [HAND_W-1:0] h, input logic [FEED_W-1:0] f,
                            input logic [SEQ_W-1:0] s);
    table_word_t w;
    w.action = act;
    w.key = k;
    w.handler = h;
    w.feed = f;
    w.seq = s;
    words_to_send.push_back(w);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        replies_due.push_back(table_apply(word_on_bus));
        words_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (words_to_send.size() > 0) begin
          word_on_bus = words_to_send.pop_front();
          action <= word_on_bus.action;
          key <= word_on_bus.key;
          handler_id <= word_on_bus.handler;
          feed_ref <= word_on_bus.feed;
          seq_in <= word_on_bus.seq;
          in_valid <= 1'b1;
          send_gap = (((words_sent / 128) % 3) == 2) ? 0 : pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    table_reply_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        replies_seen++;
        if (replies_due.size() == 0) begin
          $error("Result word arrived with no expectation pending");
          failures++;
        end else begin
          want = replies_due.pop_front();
          if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            failures++;
          end
          if (handler_out !== want.handler) begin
            $error("handler_out: expected %0d, got %0d", want.handler, handler_out);
            failures++;
          end
          if (feed_out !== want.feed) begin
            $error("feed_out: expected %0d, got %0d", want.feed, feed_out);
            failures++;
          end
          if (seq_out !== want.seq) begin
            $error("seq_out: expected %0h, got %0h", want.seq, seq_out);
            failures++;
          end
        end
      end
      if (replies_seen >= PRESSURE_AT && !pressure_done) begin
        pressure_done = 1'b1;
        hold_left = PRESSURE_CYCLES;
      end else if (hold_left == 0 && ((replies_seen / 128) % 3) != 1) begin
        hold_left = pick_gap();
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    logic [KEY_W-1:0] pool[POOL_SIZE];
    logic [KEY_W-1:0] fill_key[TABLE_DEPTH];
    logic [KEY_W-1:0] k;
    logic [1:0] act;
    int roll;
    int phase;

    queue_word(ACT_LOOKUP, '0, 4'hF, 8'hFF, 32'hFFFF_FFFF);
    queue_word(ACT_REMOVE, '0, '0, '0, '0);
    queue_word(ACT_ARM, '0, '0, '0, '0);
    queue_word(ACT_ARM, '1, 4'hF, 8'hFF, 32'hFFFF_FFFF);
    queue_word(ACT_LOOKUP, '1, '0, '0, '0);
    queue_word(ACT_SPARE, '0, '0, '0, '0);
    queue_word(ACT_ARM, '0, 4'h9, 8'hA5, 32'h1234_5678);
    queue_word(ACT_LOOKUP, '0, '0, '0, '0);
    for (int i = 2; i < TABLE_DEPTH; i++) begin
      fill_key[i] = {8'(8'h10 + i), 48'({$urandom, $urandom})};
      queue_word(ACT_ARM, fill_key[i], 4'($urandom), 8'($urandom), $urandom);
    end
    queue_word(ACT_ARM, 56'h00_DEAD_BEEF_0001, 4'h3, 8'h3C, 32'h0BAD_F00D);
    queue_word(ACT_ARM, '1, 4'h1, 8'h01, 32'h0000_0001);
    queue_word(ACT_REMOVE, '0, '0, '0, '0);
    queue_word(ACT_REMOVE, fill_key[7], '0, '0, '0);
    queue_word(ACT_REMOVE, fill_key[TABLE_DEPTH-1], '0, '0, '0);
    queue_word(ACT_LOOKUP, fill_key[8], '0, '0, '0);
    queue_word(ACT_SPARE, '1, '0, '0, '0);

    for (int i = 0; i < POOL_SIZE; i++) begin
      pool[i] = 56'({$urandom, $urandom});
    end
    pool[0] = '0;
    pool[1] = '1;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      phase = (n / 150) % 3;
      roll = $urandom_range(0, 99);
      if (phase == 0) begin
        act = (roll < 55) ? ACT_ARM : (roll < 70) ? ACT_REMOVE : ACT_LOOKUP;
      end else if (phase == 1) begin
        act = (roll < 20) ? ACT_ARM : (roll < 65) ? ACT_REMOVE : ACT_LOOKUP;
      end else begin
        act = (roll < 35) ? ACT_ARM : (roll < 60) ? ACT_REMOVE : ACT_LOOKUP;
      end
      if (act == ACT_LOOKUP && $urandom_range(0, 9) == 0) act = ACT_SPARE;
      if ($urandom_range(0, 99) < 85) k = pool[$urandom_range(0, POOL_SIZE - 1)];
      else k = 56'({$urandom, $urandom});
      queue_word(act, k, 4'($urandom), 8'($urandom), $urandom);
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    @(posedge clk);
    while (words_to_send.size() != 0 || in_valid || replies_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule
